// File: sv/virtual_texture_page_cache_lru_core_macros.svh
// Assertion macros shared by the page cache RTL.
`ifndef VIRTUAL_TEXTURE_PAGE_CACHE_LRU_CORE_MACROS_SVH
`define VIRTUAL_TEXTURE_PAGE_CACHE_LRU_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VTPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vtpc_pkg.sv
// Shared types, constants and helper functions of the page cache.
`timescale 1ns / 1ps
`default_nettype none

package vtpc_pkg;

    localparam int PAGE_BITS   = 6;
    localparam int KEY_BITS    = 2 * PAGE_BITS;
    localparam int MIP_BITS    = 4;
    localparam int SIDE_BITS   = 4;
    localparam int COORD_BITS  = 3;
    localparam int SLOT_BITS   = 6;
    localparam int SLOT_CAP    = 64;
    localparam int COUNT_BITS  = 7;
    localparam int STAMP_BITS  = 32;

    localparam logic [SIDE_BITS-1:0] MAX_SIDE   = 4'd8;
    localparam logic [SIDE_BITS-1:0] RESET_SIDE = 4'd8;

    typedef struct packed {
        logic [KEY_BITS-1:0]   pos;
        logic [MIP_BITS-1:0]   mip;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_BITS-1:0]  hit_idx;
        logic [COORD_BITS-1:0] hit_col;
        logic [COORD_BITS-1:0] hit_row;
        logic [MIP_BITS-1:0]   hit_mip;
        logic                  lru_found;
        logic [SLOT_BITS-1:0]  lru_idx;
        logic [COORD_BITS-1:0] lru_col;
        logic [COORD_BITS-1:0] lru_row;
        logic [KEY_BITS-1:0]   lru_pos;
    } scan_result_t;

    // Clamp the programmed side length into the supported range.
    function automatic logic [SIDE_BITS-1:0] side_eff(input logic [SIDE_BITS-1:0] raw);
        logic [SIDE_BITS-1:0] s;
        if (raw == '0) begin
            s = 4'd1;
        end else if (raw > MAX_SIDE) begin
            s = MAX_SIDE;
        end else begin
            s = raw;
        end
        return s;
    endfunction

    // Number of physical slots for an effective side length.
    function automatic logic [COUNT_BITS-1:0] slot_count(input logic [SIDE_BITS-1:0] s);
        logic [COUNT_BITS-1:0] w;
        w = {{(COUNT_BITS-SIDE_BITS){1'b0}}, s};
        return COUNT_BITS'(w * w);
    endfunction

endpackage

`default_nettype wire

// File: sv/vtpc_table.sv
// Slot table: valid bits in flip-flops and an entry memory with one write and one read port.
`timescale 1ns / 1ps
`default_nettype none

module vtpc_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          wr_en,
    input  wire logic [vtpc_pkg::SLOT_BITS-1:0] wr_addr,
    input  wire vtpc_pkg::entry_t              wr_entry,
    input  wire logic [vtpc_pkg::SLOT_BITS-1:0] rd_addr,
    output vtpc_pkg::entry_t                   rd_entry,
    output logic                               rd_valid
);

    vtpc_pkg::entry_t slot_mem_reg [vtpc_pkg::SLOT_CAP];
    logic [vtpc_pkg::SLOT_CAP-1:0] valid_reg;
    logic [vtpc_pkg::SLOT_CAP-1:0] valid_next;
    vtpc_pkg::entry_t rd_entry_reg;
    logic rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear) begin
            valid_next = '0;
        end else if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_mem_reg[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= slot_mem_reg[rd_addr];
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// File: sv/vtpc_scan.sv
// Slot scanner: walks the table one slot per cycle, finding the hit and the LRU slot.
`timescale 1ns / 1ps
`default_nettype none

module vtpc_scan (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            go,
    input  wire logic [vtpc_pkg::SIDE_BITS-1:0]  side,
    input  wire logic [vtpc_pkg::COUNT_BITS-1:0] count,
    input  wire logic [vtpc_pkg::KEY_BITS-1:0]   key,
    output logic [vtpc_pkg::SLOT_BITS-1:0]       rd_addr,
    input  wire vtpc_pkg::entry_t                rd_entry,
    input  wire logic                            rd_valid,
    output logic                                 done,
    output vtpc_pkg::scan_result_t               result
);

    logic                              active_reg, active_next;
    logic [vtpc_pkg::COUNT_BITS-1:0]   idx_reg, idx_next;
    logic [vtpc_pkg::COORD_BITS-1:0]   col_reg, col_next;
    logic [vtpc_pkg::COORD_BITS-1:0]   row_reg, row_next;
    logic                              chk_reg;
    logic                              last_d_reg;
    logic [vtpc_pkg::SLOT_BITS-1:0]    idx_d_reg;
    logic [vtpc_pkg::COORD_BITS-1:0]   col_d_reg, row_d_reg;
    logic                              done_reg;
    vtpc_pkg::scan_result_t            res_reg, res_next;
    logic [vtpc_pkg::STAMP_BITS-1:0]   lru_stamp_reg, lru_stamp_next;
    logic                              is_last;
    logic                              col_wrap;

    assign is_last  = (idx_reg == count - 1'b1);
    assign col_wrap = ({1'b0, col_reg} == side - 1'b1);
    assign rd_addr  = idx_reg[vtpc_pkg::SLOT_BITS-1:0];

    // Issue side: one table address per cycle with its column and row.
    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (go) begin
            active_next = 1'b1;
            idx_next    = '0;
            col_next    = '0;
            row_next    = '0;
        end else if (active_reg) begin
            idx_next = idx_reg + 1'b1;
            if (col_wrap) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
            if (is_last) begin
                active_next = 1'b0;
            end
        end
    end

    // Check side: compare the returned entry; strict less-than keeps the lowest slot on ties.
    always_comb
    begin
        res_next       = res_reg;
        lru_stamp_next = lru_stamp_reg;
        if (go) begin
            res_next.hit       = 1'b0;
            res_next.lru_found = 1'b0;
        end else if (chk_reg && rd_valid) begin
            if (!res_reg.hit && (rd_entry.pos == key)) begin
                res_next.hit     = 1'b1;
                res_next.hit_idx = idx_d_reg;
                res_next.hit_col = col_d_reg;
                res_next.hit_row = row_d_reg;
                res_next.hit_mip = rd_entry.mip;
            end
            if (!res_reg.lru_found || (rd_entry.stamp < lru_stamp_reg)) begin
                res_next.lru_found = 1'b1;
                res_next.lru_idx   = idx_d_reg;
                res_next.lru_col   = col_d_reg;
                res_next.lru_row   = row_d_reg;
                res_next.lru_pos   = rd_entry.pos;
                lru_stamp_next     = rd_entry.stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            chk_reg    <= 1'b0;
            last_d_reg <= 1'b0;
            done_reg   <= 1'b0;
            res_reg    <= '0;
        end else begin
            active_reg <= active_next;
            chk_reg    <= active_reg && !go;
            last_d_reg <= active_reg && is_last;
            done_reg   <= chk_reg && last_d_reg;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        idx_d_reg     <= idx_reg[vtpc_pkg::SLOT_BITS-1:0];
        col_d_reg     <= col_reg;
        row_d_reg     <= row_reg;
        lru_stamp_reg <= lru_stamp_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// File: sv/virtual_texture_page_cache_lru_core.sv
// Top level of the fully associative LRU page cache.
`timescale 1ns / 1ps
`default_nettype none

`include "virtual_texture_page_cache_lru_core_macros.svh"

// A page request (page_x, page_y, mip_level) is taken at a clock edge with start high and
// busy low. The block then scans every physical slot, one slot per cycle through the single
// read port of the slot table, and keeps busy high until the result is formed. slot_count,
// the number of slots scanned, is the square of the effective side length (64 slots at the
// reset side of 8). One result follows: done is high for exactly one cycle, and the result
// fields hold until the next one. The receiver cannot stall it, so it must capture the transfer
// when done is seen. A hit reports the resident slot and its stored mip level; a miss takes
// the next free slot, highest index first, and once the slots are used up it replaces the
// least recently used page, reporting the replaced page position on evicted_x/evicted_y.
// Writing slots_per_side over the cfg channel (taken only while idle) clears the cache at
// once; no clearing pass is needed because slot validity lives in flip-flops.
module virtual_texture_page_cache_lru_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [vtpc_pkg::PAGE_BITS-1:0]  page_x,
    input  wire logic [vtpc_pkg::PAGE_BITS-1:0]  page_y,
    input  wire logic [vtpc_pkg::MIP_BITS-1:0]   mip_level,
    // result strobe and fields
    output logic                                 done,
    output logic                                 hit,
    output logic [vtpc_pkg::COORD_BITS-1:0]      slot_x,
    output logic [vtpc_pkg::COORD_BITS-1:0]      slot_y,
    output logic [vtpc_pkg::MIP_BITS-1:0]        page_mip,
    output logic                                 evicted,
    output logic [vtpc_pkg::PAGE_BITS-1:0]       evicted_x,
    output logic [vtpc_pkg::PAGE_BITS-1:0]       evicted_y,
    // configuration write channel (slots_per_side)
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [vtpc_pkg::SIDE_BITS-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg, state_next;

    // Configuration and replacement bookkeeping.
    logic [vtpc_pkg::SIDE_BITS-1:0]   side_reg, side_next;
    logic [vtpc_pkg::COUNT_BITS-1:0]  free_left_reg, free_left_next;
    logic [vtpc_pkg::COORD_BITS-1:0]  free_col_reg, free_col_next;
    logic [vtpc_pkg::COORD_BITS-1:0]  free_row_reg, free_row_next;
    logic [vtpc_pkg::STAMP_BITS-1:0]  clock_reg, clock_next;

    // Request held for the length of the scan.
    logic [vtpc_pkg::KEY_BITS-1:0]    key_reg;
    logic [vtpc_pkg::MIP_BITS-1:0]    mip_reg;

    // Result registers.
    logic                             done_reg, done_next;
    logic                             hit_reg, hit_next;
    logic [vtpc_pkg::COORD_BITS-1:0]  slot_x_reg, slot_x_next;
    logic [vtpc_pkg::COORD_BITS-1:0]  slot_y_reg, slot_y_next;
    logic [vtpc_pkg::MIP_BITS-1:0]    page_mip_reg, page_mip_next;
    logic                             evicted_reg, evicted_next;
    logic [vtpc_pkg::PAGE_BITS-1:0]   evicted_x_reg, evicted_x_next;
    logic [vtpc_pkg::PAGE_BITS-1:0]   evicted_y_reg, evicted_y_next;

    logic                             req_take;
    logic                             cfg_take;
    logic [vtpc_pkg::SIDE_BITS-1:0]   side_w;
    logic [vtpc_pkg::SIDE_BITS-1:0]   cfg_side_w;
    logic [vtpc_pkg::COUNT_BITS-1:0]  count_w;

    logic                             wr_en;
    logic [vtpc_pkg::SLOT_BITS-1:0]   wr_addr;
    vtpc_pkg::entry_t                 wr_entry;
    logic [vtpc_pkg::SLOT_BITS-1:0]   rd_addr;
    vtpc_pkg::entry_t                 rd_entry;
    logic                             rd_valid;
    logic                             scan_done;
    vtpc_pkg::scan_result_t           scan_res;

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = !busy;
    assign req_take   = start && !busy;
    assign cfg_take   = cfg_valid && cfg_ready;
    assign side_w     = vtpc_pkg::side_eff(side_reg);
    assign cfg_side_w = vtpc_pkg::side_eff(cfg_data);
    assign count_w    = vtpc_pkg::slot_count(side_w);

    vtpc_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_take),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    vtpc_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (req_take),
        .side     (side_w),
        .count    (count_w),
        .key      (key_reg),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .done     (scan_done),
        .result   (scan_res)
    );

    // Sequencer, table update and result formation.
    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        free_left_next = free_left_reg;
        free_col_next  = free_col_reg;
        free_row_next  = free_row_reg;
        clock_next     = clock_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        slot_x_next    = slot_x_reg;
        slot_y_next    = slot_y_reg;
        page_mip_next  = page_mip_reg;
        evicted_next   = evicted_reg;
        evicted_x_next = evicted_x_reg;
        evicted_y_next = evicted_y_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_entry.pos   = key_reg;
        wr_entry.mip   = mip_reg;
        wr_entry.stamp = clock_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_take) begin
                    // A new geometry empties the cache, as at reset.
                    side_next      = cfg_data;
                    free_left_next = vtpc_pkg::slot_count(cfg_side_w);
                    free_col_next  = vtpc_pkg::COORD_BITS'(cfg_side_w - 1'b1);
                    free_row_next  = vtpc_pkg::COORD_BITS'(cfg_side_w - 1'b1);
                    clock_next     = '0;
                end
                if (req_take) begin
                    // The stamp clock saturates so that old stamps never wrap past new ones.
                    // A side write in the same cycle has already restarted it from zero.
                    if (clock_next != '1) begin
                        clock_next = clock_next + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                wr_en          = 1'b1;
                done_next      = 1'b1;
                evicted_next   = 1'b0;
                evicted_x_next = '0;
                evicted_y_next = '0;
                if (scan_res.hit) begin
                    // Hit: refresh the stamp only; the stored mip level is kept.
                    wr_addr        = scan_res.hit_idx;
                    wr_entry.mip   = scan_res.hit_mip;
                    hit_next       = 1'b1;
                    slot_x_next    = scan_res.hit_col;
                    slot_y_next    = scan_res.hit_row;
                    page_mip_next  = scan_res.hit_mip;
                end else begin
                    hit_next      = 1'b0;
                    page_mip_next = mip_reg;
                    if ((free_left_reg != '0) && (free_left_reg <= count_w)) begin
                        // Free slots go out from the highest index down; the column and row
                        // of the next free slot step down with the count.
                        wr_addr        = vtpc_pkg::SLOT_BITS'(free_left_reg - 1'b1);
                        slot_x_next    = free_col_reg;
                        slot_y_next    = free_row_reg;
                        free_left_next = free_left_reg - 1'b1;
                        if (free_col_reg == '0) begin
                            free_col_next = vtpc_pkg::COORD_BITS'(side_w - 1'b1);
                            free_row_next = free_row_reg - 1'b1;
                        end else begin
                            free_col_next = free_col_reg - 1'b1;
                        end
                    end else begin
                        free_left_next = '0;
                        if (scan_res.lru_found) begin
                            wr_addr        = scan_res.lru_idx;
                            slot_x_next    = scan_res.lru_col;
                            slot_y_next    = scan_res.lru_row;
                            evicted_next   = 1'b1;
                            evicted_x_next = scan_res.lru_pos[vtpc_pkg::PAGE_BITS-1:0];
                            evicted_y_next = scan_res.lru_pos[vtpc_pkg::KEY_BITS-1:
                                                              vtpc_pkg::PAGE_BITS];
                        end else begin
                            wr_addr     = '0;
                            slot_x_next = '0;
                            slot_y_next = '0;
                        end
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            side_reg      <= vtpc_pkg::RESET_SIDE;
            free_left_reg <= vtpc_pkg::slot_count(vtpc_pkg::RESET_SIDE);
            free_col_reg  <= vtpc_pkg::COORD_BITS'(vtpc_pkg::RESET_SIDE - 1'b1);
            free_row_reg  <= vtpc_pkg::COORD_BITS'(vtpc_pkg::RESET_SIDE - 1'b1);
            clock_reg     <= '0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            free_left_reg <= free_left_next;
            free_col_reg  <= free_col_next;
            free_row_reg  <= free_row_next;
            clock_reg     <= clock_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take) begin
            key_reg <= {page_y, page_x};
            mip_reg <= mip_level;
        end
        hit_reg       <= hit_next;
        slot_x_reg    <= slot_x_next;
        slot_y_reg    <= slot_y_next;
        page_mip_reg  <= page_mip_next;
        evicted_reg   <= evicted_next;
        evicted_x_reg <= evicted_x_next;
        evicted_y_reg <= evicted_y_next;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign slot_x    = slot_x_reg;
    assign slot_y    = slot_y_reg;
    assign page_mip  = page_mip_reg;
    assign evicted   = evicted_reg;
    assign evicted_x = evicted_x_reg;
    assign evicted_y = evicted_y_reg;

    // A hit never replaces a page.
    `VTPC_ASSERT_SAME(a_hit_no_evict, done, !(hit && evicted), "hit reported with eviction")
    // Replacement only happens once the free pool is exhausted.
    `VTPC_ASSERT_SAME(a_evict_pool_empty, done && evicted, free_left_reg == '0,
                      "eviction while free slots remain")
    // Without a replacement the evicted position reads as zero.
    `VTPC_ASSERT_SAME(a_evict_pos_zero, done && !evicted,
                      (evicted_x == '0) && (evicted_y == '0), "stale evicted position")
    // A taken request holds the block busy in the following cycle.
    `VTPC_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken but block not busy")

endmodule

`default_nettype wire
